// ----- sv/msbi_pkg.sv -----
// Shared constants, types and helper functions for the moment source injector.
// Used by msbi_front, msbi_queue, msbi_back and the top level; depends on nothing.
package msbi_pkg;

   // Position fraction bits and the 3x3 neighbourhood
   localparam int FRAC_BITS = 8;
   localparam int NBR_SIDE  = 3;

   // Field widths
   localparam int POS_W  = 20;
   localparam int M_W    = 24;
   localparam int IDX_W  = 25;
   localparam int SRC_W  = 16;
   localparam int INJ_W  = 44;
   localparam int DER_W  = 36;
   localparam int WSO_W  = 19;
   localparam int GD_W   = 12;
   localparam int PAD_W  = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_DEPTH    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_THICKNESS = 1'b1;
   localparam logic [GD_W-1:0]  GRID_DEPTH_RESET = 12'd256;
   localparam logic [PAD_W-1:0] PAD_RESET        = 8'd20;

   // Output scales
   localparam int OUT_FRAC_I = 16;
   localparam int OUT_FRAC_D = 8;

   // Internal widths
   localparam int SKEW_W = FRAC_BITS + 1;
   localparam int RND_W  = POS_W + 1 - FRAC_BITS;
   localparam int RXP_W  = ((RND_W > PAD_W) ? RND_W : PAD_W) + 1;
   localparam int NZP_W  = GD_W + 1;
   localparam int COLP_W = RXP_W + NZP_W;
   localparam int WT_W   = 2 * SKEW_W;
   localparam int AB_W   = SKEW_W + 1;
   localparam int WS_W   = 2 * FRAC_BITS + 2;
   localparam int DS_W   = FRAC_BITS + 3;
   localparam int PI_W   = M_W + WS_W;
   localparam int PD_W   = M_W + DS_W;
   localparam int IS_W   = PI_W + 1;
   localparam int DSUM_W = PD_W + 1;

   // Rescale shifts: one of each pair is zero
   localparam int SHL_I = (2 * FRAC_BITS < OUT_FRAC_I) ? OUT_FRAC_I - 2 * FRAC_BITS : 0;
   localparam int SHR_I = (2 * FRAC_BITS > OUT_FRAC_I) ? 2 * FRAC_BITS - OUT_FRAC_I : 0;
   localparam int SHL_D = (FRAC_BITS < OUT_FRAC_D) ? OUT_FRAC_D - FRAC_BITS : 0;
   localparam int SHR_D = (FRAC_BITS > OUT_FRAC_D) ? FRAC_BITS - OUT_FRAC_D : 0;
   localparam int EXT_I = IS_W + SHL_I + INJ_W;
   localparam int EXT_D = DSUM_W + SHL_D + DER_W;
   localparam int EXT_W = WS_W + SHL_I + WSO_W;

   // Stream word layout
   localparam int OFF_PZ       = POS_W;
   localparam int OFF_M11      = 2 * POS_W;
   localparam int OFF_M12      = OFF_M11 + M_W;
   localparam int OFF_M22      = OFF_M12 + M_W;
   localparam int REQ_FIELDS_W = 2 * POS_W + 3 * M_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = IDX_W + SRC_W + 2 * INJ_W + 4 * DER_W + 2 * WSO_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [SKEW_W-1:0] SKEW_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // Lower-left (dx, dz) of each corner block: NE, SE, SW, NW
   localparam int CORNER_DX [4] = '{0, 0, -1, -1};
   localparam int CORNER_DZ [4] = '{-1, 0, 0, -1};

   typedef logic [1:0] cellpos_type;
   localparam cellpos_type LAST_POS = 2'(NBR_SIDE - 1);

   typedef logic signed [WS_W-1:0] wsum_type;

   // One classified source, as held in the queue
   typedef struct packed {
      logic signed [WT_W-1:0] w0;
      logic signed [WT_W-1:0] w1;
      logic signed [WT_W-1:0] w2;
      logic signed [WT_W-1:0] w3;
      logic signed [AB_W-1:0] a0;
      logic signed [AB_W-1:0] a1;
      logic signed [AB_W-1:0] a2;
      logic signed [AB_W-1:0] a3;
      logic signed [AB_W-1:0] b0;
      logic signed [AB_W-1:0] b1;
      logic signed [AB_W-1:0] b2;
      logic signed [AB_W-1:0] b3;
      logic signed [M_W-1:0]  m11;
      logic signed [M_W-1:0]  m12;
      logic signed [M_W-1:0]  m22;
      logic [IDX_W-1:0]       col_prod;
      logic [RXP_W-1:0]       rz_pad;
      logic [NZP_W-1:0]       nzp;
      logic [SRC_W-1:0]       src;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Skew from the fraction: one when whole, else the fraction with its top bit flipped
   function automatic logic [SKEW_W-1:0] skew_of(input logic [FRAC_BITS-1:0] frac);
      if (frac == '0) begin
         return SKEW_ONE;
      end
      return {1'b0, ~frac[FRAC_BITS-1], frac[FRAC_BITS-2:0]};
   endfunction

   // Round half up to a whole grid coordinate
   function automatic logic [RND_W-1:0] round_of(input logic [POS_W-1:0] p);
      return RND_W'(p[POS_W-1:FRAC_BITS]) + RND_W'(p[FRAC_BITS-1]);
   endfunction

   // Sum of the corner quantities that land on one cell, signed by the x or z stencil
   function automatic wsum_type cell_sum(input cellpos_type col, input cellpos_type row,
                                         input logic z_axis,
                                         input wsum_type q0, input wsum_type q1,
                                         input wsum_type q2, input wsum_type q3);
      wsum_type q [4];
      wsum_type acc;
      int       dx;
      int       dz;
      logic     in_x;
      logic     in_z;
      logic     upper;
      q   = '{q0, q1, q2, q3};
      acc = '0;
      dx  = int'(col) - 1;
      dz  = int'(row) - 1;
      for (int c = 0; c < 4; c++) begin
         in_x  = (dx == CORNER_DX[c]) || (dx == CORNER_DX[c] + 1);
         in_z  = (dz == CORNER_DZ[c]) || (dz == CORNER_DZ[c] + 1);
         upper = z_axis ? (dz == CORNER_DZ[c] + 1) : (dx == CORNER_DX[c] + 1);
         if (in_x && in_z) begin
            acc = upper ? acc + q[c] : acc - q[c];
         end
      end
      return acc;
   endfunction

endpackage

// ----- sv/msbi_queue.sv -----
// Short register queue of classified sources between front and back.
// Depends on msbi_pkg for the entry and status types.
module msbi_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  msbi_pkg::job_type    push_job,
   input  logic                 pop,
   output msbi_pkg::job_type    head_job,
   output msbi_pkg::q_stat_type q_stat
);
   import msbi_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry at the tail
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = store_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

// ----- sv/msbi_front.sv -----
// Front end: configuration registers, source counter, skew, weights and index base.
// Two register stages feed msbi_queue; depends on msbi_pkg.
module msbi_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x, pos_z, moment_xx, moment_xz, moment_zz
   input  logic [msbi_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                csr_wen,
   input  logic [msbi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [msbi_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  msbi_pkg::q_stat_type                q_stat,
   output logic                                push,
   output msbi_pkg::job_type                   push_job
);
   import msbi_pkg::*;

   logic [GD_W-1:0]  grid_depth_ff;
   logic [PAD_W-1:0] pad_ff;
   logic [SRC_W-1:0] src_ff;

   logic adv;
   logic accept;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;

   logic [POS_W-1:0]  px, pz;
   logic [RND_W-1:0]  rx, rz;
   logic [SKEW_W-1:0] xs_in, zs_in;

   logic [SKEW_W-1:0]      s1_xs_ff, s1_zs_ff, s1_xc_ff, s1_zc_ff;
   logic [RXP_W-1:0]       s1_rx_pad_ff, s1_rz_pad_ff;
   logic [NZP_W-1:0]       s1_nzp_ff;
   logic signed [M_W-1:0]  s1_m11_ff, s1_m12_ff, s1_m22_ff;
   logic [SRC_W-1:0]       s1_src_ff;

   logic [WT_W-1:0]   w0_u, w1_u, w2_u, w3_u;
   logic [COLP_W-1:0] col_full;
   job_type           job_in;
   job_type           s2_job_ff;

   // Hold the whole front while the queue is full and stage 2 holds a source
   assign adv        = !s2_valid_ff || !q_stat.full;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;
   assign push       = s2_valid_ff && !q_stat.full;
   assign push_job   = s2_job_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_depth_ff <= GRID_DEPTH_RESET;
         pad_ff        <= PAD_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_GRID_DEPTH:    grid_depth_ff <= csr_wdata[GD_W-1:0];
            REG_PAD_THICKNESS: pad_ff        <= csr_wdata[PAD_W-1:0];
         endcase
      end
   end

   // Count sources as they are taken
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= '0;
      end else if (accept) begin
         src_ff <= src_ff + SRC_W'(1);
      end
   end

   // Stage valid flags
   always_comb begin
      s1_valid_in = adv ? accept : s1_valid_ff;
      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage 1: round and pad positions, form skews and their complements
   always_comb begin
      px    = req_tdata[POS_W-1:0];
      pz    = req_tdata[OFF_PZ +: POS_W];
      rx    = round_of(px);
      rz    = round_of(pz);
      xs_in = skew_of(px[FRAC_BITS-1:0]);
      zs_in = skew_of(pz[FRAC_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_xs_ff     <= xs_in;
         s1_zs_ff     <= zs_in;
         s1_xc_ff     <= SKEW_ONE - xs_in;
         s1_zc_ff     <= SKEW_ONE - zs_in;
         s1_rx_pad_ff <= RXP_W'(rx) + RXP_W'(pad_ff);
         s1_rz_pad_ff <= RXP_W'(rz) + RXP_W'(pad_ff);
         s1_nzp_ff    <= NZP_W'(grid_depth_ff) + NZP_W'({pad_ff, 1'b0});
         s1_m11_ff    <= req_tdata[OFF_M11 +: M_W];
         s1_m12_ff    <= req_tdata[OFF_M12 +: M_W];
         s1_m22_ff    <= req_tdata[OFF_M22 +: M_W];
         s1_src_ff    <= src_ff;
      end
   end

   // Stage 2: corner weights, skew derivatives and column product
   always_comb begin
      w0_u     = WT_W'(s1_zc_ff) * WT_W'(s1_xs_ff);
      w1_u     = WT_W'(s1_zs_ff) * WT_W'(s1_xs_ff);
      w2_u     = WT_W'(s1_zs_ff) * WT_W'(s1_xc_ff);
      w3_u     = WT_W'(s1_zc_ff) * WT_W'(s1_xc_ff);
      col_full = COLP_W'(s1_rx_pad_ff) * COLP_W'(s1_nzp_ff);

      job_in.w0       = $signed(w0_u);
      job_in.w1       = $signed(w1_u);
      job_in.w2       = $signed(w2_u);
      job_in.w3       = $signed(w3_u);
      job_in.a0       = $signed({1'b0, s1_zc_ff});
      job_in.a1       = $signed({1'b0, s1_zs_ff});
      job_in.a2       = -$signed({1'b0, s1_zs_ff});
      job_in.a3       = -$signed({1'b0, s1_zc_ff});
      job_in.b0       = -$signed({1'b0, s1_xs_ff});
      job_in.b1       = $signed({1'b0, s1_xs_ff});
      job_in.b2       = $signed({1'b0, s1_xc_ff});
      job_in.b3       = -$signed({1'b0, s1_xc_ff});
      job_in.m11      = s1_m11_ff;
      job_in.m12      = s1_m12_ff;
      job_in.m22      = s1_m22_ff;
      job_in.col_prod = IDX_W'(col_full);
      job_in.rz_pad   = s1_rz_pad_ff;
      job_in.nzp      = s1_nzp_ff;
      job_in.src      = s1_src_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_job_ff <= job_in;
      end
   end

endmodule

// ----- sv/msbi_back.sv -----
// Back end: walks the nine neighbour cells of each queued source, one a cycle unless the output stalls.
// Cell sums, products and rescaled output register; depends on msbi_pkg.
module msbi_back (
   input  logic                             clock,
   input  logic                             reset,
   input  msbi_pkg::job_type                head_job,
   input  msbi_pkg::q_stat_type             q_stat,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // cell_index, source_number, inject_x, inject_z, dx_of_inject_x, dx_of_inject_z,
   // dz_of_inject_x, dz_of_inject_z, weight_sum_dx, weight_sum_dz, zero fill
   output logic [msbi_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // last_cell
   output logic                             rsp_tlast
);
   import msbi_pkg::*;

   // Rescale helpers: left shift to grow the scale, floor shift to shrink it
   function automatic logic [INJ_W-1:0] rescale_i(input logic signed [IS_W-1:0] v);
      logic signed [EXT_I-1:0] e;
      e = EXT_I'(v);
      e = (e <<< SHL_I) >>> SHR_I;
      return e[INJ_W-1:0];
   endfunction

   function automatic logic [DER_W-1:0] rescale_d(input logic signed [DSUM_W-1:0] v);
      logic signed [EXT_D-1:0] e;
      e = EXT_D'(v);
      e = (e <<< SHL_D) >>> SHR_D;
      return e[DER_W-1:0];
   endfunction

   function automatic logic [WSO_W-1:0] rescale_w(input logic signed [WS_W-1:0] v);
      logic signed [EXT_W-1:0] e;
      e = EXT_W'(v);
      e = (e <<< SHL_I) >>> SHR_I;
      return e[WSO_W-1:0];
   endfunction

   logic en;
   logic at_last;
   logic load;

   // Sequencer state
   logic              have_ff, have_in;
   job_type           cur_ff, cur_in;
   cellpos_type       col_ff, col_in, row_ff, row_in;
   logic [IDX_W-1:0]  col_base_ff, col_base_in;

   // Stage B1: cell sums
   wsum_type          ax_full, az_full, bx_full, bz_full;
   logic              b1_valid_ff;
   wsum_type          b1_wsx_ff, b1_wsz_ff;
   logic signed [DS_W-1:0] b1_ax_ff, b1_az_ff, b1_bx_ff, b1_bz_ff;
   logic signed [M_W-1:0]  b1_m11_ff, b1_m12_ff, b1_m22_ff;
   logic [IDX_W-1:0]  b1_idx_ff;
   logic [SRC_W-1:0]  b1_src_ff;
   logic              b1_last_ff;

   // Stage B2: products
   logic              b2_valid_ff;
   logic signed [PI_W-1:0] b2_p11_wx_ff, b2_p12_wz_ff, b2_p22_wz_ff, b2_p12_wx_ff;
   logic signed [PD_W-1:0] b2_p11_ax_ff, b2_p12_az_ff, b2_p22_az_ff, b2_p12_ax_ff;
   logic signed [PD_W-1:0] b2_p11_bx_ff, b2_p12_bz_ff, b2_p22_bz_ff, b2_p12_bx_ff;
   wsum_type          b2_wsx_ff, b2_wsz_ff;
   logic [IDX_W-1:0]  b2_idx_ff;
   logic [SRC_W-1:0]  b2_src_ff;
   logic              b2_last_ff;

   // Output register
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [SRC_W-1:0]  rsp_src_ff;
   logic [INJ_W-1:0]  rsp_ix_ff, rsp_iz_ff;
   logic [DER_W-1:0]  rsp_dxx_ff, rsp_dxz_ff, rsp_dzx_ff, rsp_dzz_ff;
   logic [WSO_W-1:0]  rsp_wsx_ff, rsp_wsz_ff;
   logic              rsp_last_ff;

   logic signed [IS_W-1:0]   sum_ix, sum_iz;
   logic signed [DSUM_W-1:0] sum_dxx, sum_dxz, sum_dzx, sum_dzz;

   // Advance the whole back end unless the output word is stalled
   assign en      = !rsp_valid_ff || rsp_tready;
   assign at_last = (col_ff == LAST_POS) && (row_ff == LAST_POS);
   assign load    = (!have_ff || at_last) && !q_stat.empty;
   assign pop     = en && load;

   // Step through the cells, depth fastest; take the next source on the ninth
   always_comb begin
      have_in     = have_ff;
      cur_in      = cur_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      col_base_in = col_base_ff;
      if (en) begin
         if (!have_ff || at_last) begin
            have_in = !q_stat.empty;
            if (!q_stat.empty) begin
               cur_in      = head_job;
               col_in      = '0;
               row_in      = '0;
               col_base_in = head_job.col_prod + IDX_W'(head_job.rz_pad)
                           - IDX_W'(head_job.nzp) - IDX_W'(1);
            end
         end else if (row_ff == LAST_POS) begin
            row_in      = '0;
            col_in      = col_ff + cellpos_type'(1);
            col_base_in = col_base_ff + IDX_W'(cur_ff.nzp);
         end else begin
            row_in = row_ff + cellpos_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         have_ff <= have_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      col_base_ff <= col_base_in;
   end

   // Skew-derivative sums at full width, narrowed below
   always_comb begin
      ax_full = cell_sum(col_ff, row_ff, 1'b0, WS_W'(cur_ff.a0), WS_W'(cur_ff.a1),
                         WS_W'(cur_ff.a2), WS_W'(cur_ff.a3));
      az_full = cell_sum(col_ff, row_ff, 1'b1, WS_W'(cur_ff.a0), WS_W'(cur_ff.a1),
                         WS_W'(cur_ff.a2), WS_W'(cur_ff.a3));
      bx_full = cell_sum(col_ff, row_ff, 1'b0, WS_W'(cur_ff.b0), WS_W'(cur_ff.b1),
                         WS_W'(cur_ff.b2), WS_W'(cur_ff.b3));
      bz_full = cell_sum(col_ff, row_ff, 1'b1, WS_W'(cur_ff.b0), WS_W'(cur_ff.b1),
                         WS_W'(cur_ff.b2), WS_W'(cur_ff.b3));
   end

   // Stage B1: gather every corner's share on this cell
   always_ff @(posedge clock) begin
      if (en) begin
         b1_wsx_ff  <= cell_sum(col_ff, row_ff, 1'b0, cur_ff.w0, cur_ff.w1,
                                cur_ff.w2, cur_ff.w3);
         b1_wsz_ff  <= cell_sum(col_ff, row_ff, 1'b1, cur_ff.w0, cur_ff.w1,
                                cur_ff.w2, cur_ff.w3);
         b1_ax_ff   <= ax_full[DS_W-1:0];
         b1_az_ff   <= az_full[DS_W-1:0];
         b1_bx_ff   <= bx_full[DS_W-1:0];
         b1_bz_ff   <= bz_full[DS_W-1:0];
         b1_m11_ff  <= cur_ff.m11;
         b1_m12_ff  <= cur_ff.m12;
         b1_m22_ff  <= cur_ff.m22;
         b1_idx_ff  <= col_base_ff + IDX_W'(row_ff);
         b1_src_ff  <= cur_ff.src;
         b1_last_ff <= at_last;
      end
   end

   // Stage B2: moment products
   always_ff @(posedge clock) begin
      if (en) begin
         b2_p11_wx_ff <= b1_m11_ff * b1_wsx_ff;
         b2_p12_wz_ff <= b1_m12_ff * b1_wsz_ff;
         b2_p22_wz_ff <= b1_m22_ff * b1_wsz_ff;
         b2_p12_wx_ff <= b1_m12_ff * b1_wsx_ff;
         b2_p11_ax_ff <= b1_m11_ff * b1_ax_ff;
         b2_p12_az_ff <= b1_m12_ff * b1_az_ff;
         b2_p22_az_ff <= b1_m22_ff * b1_az_ff;
         b2_p12_ax_ff <= b1_m12_ff * b1_ax_ff;
         b2_p11_bx_ff <= b1_m11_ff * b1_bx_ff;
         b2_p12_bz_ff <= b1_m12_ff * b1_bz_ff;
         b2_p22_bz_ff <= b1_m22_ff * b1_bz_ff;
         b2_p12_bx_ff <= b1_m12_ff * b1_bx_ff;
         b2_wsx_ff    <= b1_wsx_ff;
         b2_wsz_ff    <= b1_wsz_ff;
         b2_idx_ff    <= b1_idx_ff;
         b2_src_ff    <= b1_src_ff;
         b2_last_ff   <= b1_last_ff;
      end
   end

   // Pair the products
   always_comb begin
      sum_ix  = IS_W'(b2_p11_wx_ff) + IS_W'(b2_p12_wz_ff);
      sum_iz  = IS_W'(b2_p22_wz_ff) + IS_W'(b2_p12_wx_ff);
      sum_dxx = DSUM_W'(b2_p11_ax_ff) + DSUM_W'(b2_p12_az_ff);
      sum_dxz = DSUM_W'(b2_p22_az_ff) + DSUM_W'(b2_p12_ax_ff);
      sum_dzx = DSUM_W'(b2_p11_bx_ff) + DSUM_W'(b2_p12_bz_ff);
      sum_dzz = DSUM_W'(b2_p22_bz_ff) + DSUM_W'(b2_p12_bx_ff);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_idx_ff  <= b2_idx_ff;
         rsp_src_ff  <= b2_src_ff;
         rsp_ix_ff   <= rescale_i(sum_ix);
         rsp_iz_ff   <= rescale_i(sum_iz);
         rsp_dxx_ff  <= rescale_d(sum_dxx);
         rsp_dxz_ff  <= rescale_d(sum_dxz);
         rsp_dzx_ff  <= rescale_d(sum_dzx);
         rsp_dzz_ff  <= rescale_d(sum_dzz);
         rsp_wsx_ff  <= rescale_w(b2_wsx_ff);
         rsp_wsz_ff  <= rescale_w(b2_wsz_ff);
         rsp_last_ff <= b2_last_ff;
      end
   end

   // Valid flags down the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff  <= have_ff;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_wsz_ff, rsp_wsx_ff, rsp_dzz_ff, rsp_dzx_ff,
                                     rsp_dxz_ff, rsp_dxx_ff, rsp_iz_ff, rsp_ix_ff,
                                     rsp_src_ff, rsp_idx_ff});

endmodule

// ----- sv/moment_source_bilinear_injector.sv -----
// Moment source injector: one source word in, nine neighbour cell words out.
// A cell word passes front stages 1 and 2, the queue, the sequencer, B1, B2 and the output register.
// Throughput: one cell word a cycle while the output is not stalled; the cell walk sets the source rate.
// Sources are taken back to back until the queue is full and front stage 2 holds a source.
// Reset is synchronous: clears the source count, flags and queue; grid depth 256, pad 20.
// Built from msbi_front, msbi_queue and msbi_back; depends on msbi_pkg.
module moment_source_bilinear_injector #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x, pos_z, moment_xx, moment_xz, moment_zz
   input  logic [msbi_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_index, source_number, inject_x, inject_z, dx_of_inject_x, dx_of_inject_z,
   // dz_of_inject_x, dz_of_inject_z, weight_sum_dx, weight_sum_dz, zero fill
   output logic [msbi_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // last_cell
   output logic                              rsp_tlast,
   input  logic                              csr_wen,
   input  logic [msbi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msbi_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import msbi_pkg::*;

   logic       push;
   logic       pop;
   job_type    push_job;
   job_type    head_job;
   q_stat_type q_stat;

   // Classify sources
   msbi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_job   (push_job)
   );

   // Decouple front and back
   msbi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   // Emit the neighbour cells
   msbi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
